[hw/rtl/cmasp_pkg.sv]
// Shared types, constants and command/status structs for the charge monitor.
package cmasp_pkg;

   localparam int SAMPLE_W = 12;
   localparam int DIV_W    = 29;
   localparam int MAG_W    = DIV_W + 1;
   localparam int SH_W     = 6;
   localparam int PROD_W   = DIV_W + MAG_W;

   localparam int ADC_DEN  = 4095;
   localparam int FILT_DEN = 20;
   localparam int PWR_DEN  = 1000;

   // Smallest b with 2**b >= den.
   function automatic int recip_bits(input int den);
      int b;
      b = 0;
      while ((1 << b) < den) b++;
      return b;
   endfunction

   // Reciprocal giving an exact floor division of any DIV_W-bit dividend by den.
   function automatic logic [MAG_W-1:0] recip_magic(input int den);
      logic [63:0] num;
      num = 64'd1 << (DIV_W + recip_bits(den));
      return MAG_W'((num + 64'(den) - 64'd1) / 64'(den));
   endfunction

   function automatic logic [SH_W-1:0] recip_shift(input int den);
      return SH_W'(DIV_W + recip_bits(den));
   endfunction

   localparam logic [1:0] CH_CURRENT = 2'd0;
   localparam logic [1:0] CH_VIN     = 2'd1;
   localparam logic [1:0] CH_VOUT    = 2'd2;

   localparam logic [DIV_W-1:0] SCALE_CUR  = DIV_W'(5000);
   localparam logic [DIV_W-1:0] SCALE_VIN  = DIV_W'(80000);
   localparam logic [DIV_W-1:0] SCALE_VOUT = DIV_W'(20000);
   localparam logic [DIV_W-1:0] FILT_TAP   = DIV_W'(19);

   localparam logic [MAG_W-1:0] MAG_ADC  = recip_magic(ADC_DEN);
   localparam logic [SH_W-1:0]  SH_ADC   = recip_shift(ADC_DEN);
   localparam logic [MAG_W-1:0] MAG_FILT = recip_magic(FILT_DEN);
   localparam logic [SH_W-1:0]  SH_FILT  = recip_shift(FILT_DEN);
   localparam logic [MAG_W-1:0] MAG_PWR  = recip_magic(PWR_DEN);
   localparam logic [SH_W-1:0]  SH_PWR   = recip_shift(PWR_DEN);

   typedef struct packed {
      logic [1:0]          channel;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [12:0] current_ma;
      logic [16:0] input_voltage_mv;
      logic [14:0] output_voltage_mv;
      logic [18:0] power_mw;
   } rsp_type;

   typedef enum logic [2:0] {
      DIV_AVG  = 3'd0,
      DIV_CUR  = 3'd1,
      DIV_FILT = 3'd2,
      DIV_VIN  = 3'd3,
      DIV_VOUT = 3'd4,
      DIV_PWR  = 3'd5
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        div_start;
      div_sel_type start_sel;
      logic        store_en;
      div_sel_type store_sel;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic batch_end;
      logic avg_vout;
      logic div_busy;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/charge_monitor_average_scale_power_core.sv]
// A sample that does not close a batch is taken without a stall, back to back.
// Closing a current or input-voltage batch stalls the input for the average divide.
// Closing an output-voltage batch runs six reciprocal divisions in turn (average, current,
// filter, input voltage, output voltage, power); the input stalls until the item is loaded
// into the result register, which waits while the previous item still sits there.
// Synchronous reset clears sums, counts, current/Vin averages, filter history, result valid.
module charge_monitor_average_scale_power_core
   import cmasp_pkg::*;
#(
   parameter int CURRENT_SAMPLES = 8,
   parameter int VIN_SAMPLES     = 8,
   parameter int VOUT_SAMPLES    = 8
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   cmasp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cmasp_datapath #(
      .CURRENT_SAMPLES (CURRENT_SAMPLES),
      .VIN_SAMPLES     (VIN_SAMPLES),
      .VOUT_SAMPLES    (VOUT_SAMPLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/cmasp_div.sv]
// Constant divider by reciprocal multiplication, operands then product registered.
module cmasp_div
   import cmasp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [MAG_W-1:0] magic,
   input  logic [SH_W-1:0]  shift,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  op_ff, op_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] prod_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      op_in   = op_ff;
      mag_in  = mag_ff;
      sh_in   = sh_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         op_in   = dividend;
         mag_in  = magic;
         sh_in   = shift;
      end else if (busy_ff) begin
         // floor(x / d) is (x * m) >> s for every dividend below 2**DIV_W
         prod_in = PROD_W'(op_ff) * PROD_W'(mag_ff);
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      mag_ff  <= mag_in;
      sh_ff   <= sh_in;
      prod_ff <= prod_in;
   end

   assign prod_sh  = prod_ff >> sh_ff;

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = prod_sh[DIV_W-1:0];

endmodule

[hw/rtl/cmasp_acc.sv]
// Per-channel sample accumulator with batch counter.
module cmasp_acc
   import cmasp_pkg::*;
#(
   parameter int SAMPLES = 8
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                add,
   input  logic [SAMPLE_W-1:0] sample,
   output logic                last,
   output logic [DIV_W-1:0]    sum_next
);

   localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES - 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_add;

   assign sum_add  = sum_ff + SUM_W'(sample);
   assign last     = (count_ff == LAST_CNT);
   assign sum_next = DIV_W'(sum_add);

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (add) begin
         // clear at batch end, the full sum goes to the divider
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_add;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

[hw/rtl/cmasp_datapath.sv]
// Datapath: accumulators, scaling multiplies, shared divider and result register.
module cmasp_datapath
   import cmasp_pkg::*;
#(
   parameter int CURRENT_SAMPLES = 8,
   parameter int VIN_SAMPLES     = 8,
   parameter int VOUT_SAMPLES    = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam logic [MAG_W-1:0] MAG_AVG_CUR  = recip_magic(CURRENT_SAMPLES);
   localparam logic [SH_W-1:0]  SH_AVG_CUR   = recip_shift(CURRENT_SAMPLES);
   localparam logic [MAG_W-1:0] MAG_AVG_VIN  = recip_magic(VIN_SAMPLES);
   localparam logic [SH_W-1:0]  SH_AVG_VIN   = recip_shift(VIN_SAMPLES);
   localparam logic [MAG_W-1:0] MAG_AVG_VOUT = recip_magic(VOUT_SAMPLES);
   localparam logic [SH_W-1:0]  SH_AVG_VOUT  = recip_shift(VOUT_SAMPLES);

   logic             cur_last, vin_last, vout_last;
   logic [DIV_W-1:0] cur_sum, vin_sum, vout_sum;
   logic             div_busy, div_done;
   logic [DIV_W-1:0] quot;
   logic [DIV_W-1:0] dividend;
   logic [MAG_W-1:0] div_magic;
   logic [SH_W-1:0]  div_shift;
   logic [DIV_W-1:0] prod_cur, prod_filt, prod_vin, prod_vout, prod_pwr;
   logic             batch_end;

   logic [1:0]          ch_ff, ch_in;
   logic [SAMPLE_W-1:0] cur_avg_ff, cur_avg_in;
   logic [SAMPLE_W-1:0] vin_avg_ff, vin_avg_in;
   logic [SAMPLE_W-1:0] vout_avg_ff, vout_avg_in;
   logic [12:0]         filt_ff, filt_in;
   logic [16:0]         vin_ff, vin_in;
   logic [14:0]         vout_ff, vout_in;
   logic [12:0]         prev_ff, prev_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   cmasp_acc #(.SAMPLES(CURRENT_SAMPLES)) u_acc_cur (
      .clock    (clock),
      .reset    (reset),
      .add      (cmd.accept && req_data.channel == CH_CURRENT),
      .sample   (req_data.sample),
      .last     (cur_last),
      .sum_next (cur_sum)
   );

   cmasp_acc #(.SAMPLES(VIN_SAMPLES)) u_acc_vin (
      .clock    (clock),
      .reset    (reset),
      .add      (cmd.accept && req_data.channel == CH_VIN),
      .sample   (req_data.sample),
      .last     (vin_last),
      .sum_next (vin_sum)
   );

   cmasp_acc #(.SAMPLES(VOUT_SAMPLES)) u_acc_vout (
      .clock    (clock),
      .reset    (reset),
      .add      (cmd.accept && req_data.channel == CH_VOUT),
      .sample   (req_data.sample),
      .last     (vout_last),
      .sum_next (vout_sum)
   );

   cmasp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .magic    (div_magic),
      .shift    (div_shift),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quot)
   );

   assign prod_cur  = DIV_W'(cur_avg_ff) * SCALE_CUR;
   assign prod_filt = DIV_W'(quot[12:0]) * FILT_TAP + DIV_W'(prev_ff);
   assign prod_vin  = DIV_W'(vin_avg_ff) * SCALE_VIN;
   assign prod_vout = DIV_W'(vout_avg_ff) * SCALE_VOUT;
   assign prod_pwr  = DIV_W'(vin_ff) * DIV_W'(filt_ff);

   always_comb begin
      unique case (req_data.channel)
         CH_CURRENT: batch_end = cur_last;
         CH_VIN:     batch_end = vin_last;
         CH_VOUT:    batch_end = vout_last;
         default:    batch_end = 1'b0;
      endcase
   end

   // operand select for the division being started
   always_comb begin
      dividend  = prod_cur;
      div_magic = MAG_ADC;
      div_shift = SH_ADC;
      unique case (cmd.start_sel)
         DIV_AVG: begin
            unique case (req_data.channel)
               CH_CURRENT: begin
                  dividend  = cur_sum;
                  div_magic = MAG_AVG_CUR;
                  div_shift = SH_AVG_CUR;
               end
               CH_VIN: begin
                  dividend  = vin_sum;
                  div_magic = MAG_AVG_VIN;
                  div_shift = SH_AVG_VIN;
               end
               default: begin
                  dividend  = vout_sum;
                  div_magic = MAG_AVG_VOUT;
                  div_shift = SH_AVG_VOUT;
               end
            endcase
         end
         DIV_CUR: begin
            dividend  = prod_cur;
            div_magic = MAG_ADC;
            div_shift = SH_ADC;
         end
         DIV_FILT: begin
            dividend  = prod_filt;
            div_magic = MAG_FILT;
            div_shift = SH_FILT;
         end
         DIV_VIN: begin
            dividend  = prod_vin;
            div_magic = MAG_ADC;
            div_shift = SH_ADC;
         end
         DIV_VOUT: begin
            dividend  = prod_vout;
            div_magic = MAG_ADC;
            div_shift = SH_ADC;
         end
         DIV_PWR: begin
            dividend  = prod_pwr;
            div_magic = MAG_PWR;
            div_shift = SH_PWR;
         end
      endcase
   end

   always_comb begin
      ch_in        = ch_ff;
      cur_avg_in   = cur_avg_ff;
      vin_avg_in   = vin_avg_ff;
      vout_avg_in  = vout_avg_ff;
      filt_in      = filt_ff;
      vin_in       = vin_ff;
      vout_in      = vout_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.accept) begin
         ch_in = req_data.channel;
      end
      if (cmd.store_en) begin
         unique case (cmd.store_sel)
            DIV_AVG: begin
               unique case (ch_ff)
                  CH_CURRENT: cur_avg_in  = quot[SAMPLE_W-1:0];
                  CH_VIN:     vin_avg_in  = quot[SAMPLE_W-1:0];
                  default:    vout_avg_in = quot[SAMPLE_W-1:0];
               endcase
            end
            DIV_FILT: filt_in = quot[12:0];
            DIV_VIN:  vin_in  = quot[16:0];
            DIV_VOUT: vout_in = quot[14:0];
            DIV_CUR, DIV_PWR: begin
               // used straight from the divider
            end
         endcase
      end
      if (cmd.load_out) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.current_ma        = filt_ff;
         rsp_data_in.input_voltage_mv  = vin_ff;
         rsp_data_in.output_voltage_mv = vout_ff;
         rsp_data_in.power_mw          = quot[18:0];
         prev_in                       = filt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_avg_ff   <= '0;
         vin_avg_ff   <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_avg_ff   <= cur_avg_in;
         vin_avg_ff   <= vin_avg_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      vout_avg_ff <= vout_avg_in;
      filt_ff     <= filt_in;
      vin_ff      <= vin_in;
      vout_ff     <= vout_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.batch_end = batch_end;
   assign status.avg_vout  = (ch_ff == CH_VOUT);
   assign status.div_busy  = div_busy;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/cmasp_ctrl.sv]
// Controller: sequences accumulation, averaging and the scaling divisions.
module cmasp_ctrl
   import cmasp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_AVG  = 7'b0000010,
      ST_CUR  = 7'b0000100,
      ST_FILT = 7'b0001000,
      ST_VIN  = 7'b0010000,
      ST_VOUT = 7'b0100000,
      ST_PWR  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.div_start = 1'b0;
      cmd.start_sel = DIV_AVG;
      cmd.store_en  = 1'b0;
      cmd.store_sel = DIV_AVG;
      cmd.load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.batch_end) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DIV_AVG;
               state_in      = ST_AVG;
            end
         end
         ST_AVG: begin
            cmd.store_en  = status.div_done;
            cmd.store_sel = DIV_AVG;
            if (status.div_done) begin
               // only an output-voltage batch produces an item
               if (status.avg_vout) begin
                  cmd.div_start = 1'b1;
                  cmd.start_sel = DIV_CUR;
                  state_in      = ST_CUR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CUR: begin
            cmd.store_sel = DIV_CUR;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DIV_FILT;
               state_in      = ST_FILT;
            end
         end
         ST_FILT: begin
            cmd.store_en  = status.div_done;
            cmd.store_sel = DIV_FILT;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DIV_VIN;
               state_in      = ST_VIN;
            end
         end
         ST_VIN: begin
            cmd.store_en  = status.div_done;
            cmd.store_sel = DIV_VIN;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DIV_VOUT;
               state_in      = ST_VOUT;
            end
         end
         ST_VOUT: begin
            cmd.store_en  = status.div_done;
            cmd.store_sel = DIV_VOUT;
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.start_sel = DIV_PWR;
               state_in      = ST_PWR;
            end
         end
         ST_PWR: begin
            cmd.store_sel = DIV_PWR;
            // hold until the result register is free
            if (status.div_done && status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("division started while divider busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

   a_store_done: assert property (@(posedge clock) disable iff (reset)
      cmd.store_en |-> status.div_done)
      else $error("quotient stored before division finished");

endmodule

[verif/tb_charge_monitor_average_scale_power_core.sv]
// Self-checking testbench for the charge monitor averaging, scaling and power core.
module tb_charge_monitor_average_scale_power_core;
   import cmasp_pkg::*;

   localparam int AMPS_BATCH      = 8;
   localparam int VIN_BATCH       = 8;
   localparam int VOUT_BATCH      = 8;
   localparam int ADC_FULL        = 4095;
   localparam int MA_FULL_SCALE   = 5000;
   localparam int VIN_FULL_SCALE  = 80000;
   localparam int VOUT_FULL_SCALE = 20000;
   localparam int FILTER_NEW_TAP  = 19;
   localparam int FILTER_DIV      = 20;
   localparam int MW_DIV          = 1000;
   localparam logic [1:0] CH_UNUSED = 2'd3;

   localparam int RANDOM_SAMPLES  = 480;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 250;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   charge_monitor_average_scale_power_core #(
      .CURRENT_SAMPLES(AMPS_BATCH),
      .VIN_SAMPLES    (VIN_BATCH),
      .VOUT_SAMPLES   (VOUT_BATCH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   typedef struct {
      logic [1:0]  channel;
      logic [11:0] sample;
      int          reps;
      bit          typed;
      rsp_type     want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 5;

   // Full-scale current with no input-voltage batch yet: filter starts from zero.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CH_UNUSED,  12'hFFF, 1, 1'b0, '0},
      '{CH_UNUSED,  12'h000, 1, 1'b0, '0},
      '{CH_CURRENT, 12'hFFF, 8, 1'b0, '0},
      '{CH_VOUT,    12'hFFF, 8, 1'b1, rsp_type'{13'd4750, 17'd0, 15'd20000, 19'd0}},
      '{CH_VIN,     12'hFFF, 3, 1'b0, '0}
   };

   // Predictor state
   int unsigned amps_total, vin_total, vout_total;
   int unsigned amps_taken, vin_taken, vout_taken;
   int unsigned amps_mean, vin_mean;
   int unsigned filtered_ma;

   rsp_type expected_readings [$];
   int      mismatches;
   int      readings_checked;
   int      readings_due;
   int      samples_taken;
   int      samples_ignored;
   int      hold_off_requests = 0;
   bit      steady_phase;
   int      level_mode [4];

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic bit predict_reading(input req_type item, output rsp_type reading);
      int unsigned vout_mean, ma, filt, vin_mv, vout_mv, mw;
      reading = '0;
      case (item.channel)
         CH_CURRENT: begin
            amps_total += item.sample;
            amps_taken++;
            if (amps_taken == AMPS_BATCH) begin
               amps_mean  = amps_total / AMPS_BATCH;
               amps_total = 0;
               amps_taken = 0;
            end
            return 1'b0;
         end
         CH_VIN: begin
            vin_total += item.sample;
            vin_taken++;
            if (vin_taken == VIN_BATCH) begin
               vin_mean  = vin_total / VIN_BATCH;
               vin_total = 0;
               vin_taken = 0;
            end
            return 1'b0;
         end
         CH_VOUT: begin
            vout_total += item.sample;
            vout_taken++;
            if (vout_taken != VOUT_BATCH) return 1'b0;
            vout_mean  = vout_total / VOUT_BATCH;
            vout_total = 0;
            vout_taken = 0;
            ma      = amps_mean * MA_FULL_SCALE / ADC_FULL;
            filt    = (FILTER_NEW_TAP * ma + filtered_ma) / FILTER_DIV;
            vin_mv  = vin_mean * VIN_FULL_SCALE / ADC_FULL;
            vout_mv = vout_mean * VOUT_FULL_SCALE / ADC_FULL;
            mw      = vin_mv * filt / MW_DIV;
            filtered_ma = filt;
            reading.current_ma        = 13'(filt);
            reading.input_voltage_mv  = 17'(vin_mv);
            reading.output_voltage_mv = 15'(vout_mv);
            reading.power_mw          = 19'(mw);
            return 1'b1;
         end
         default: return 1'b0;  // unused channel code: drop
      endcase
   endfunction

   // Present one item, hold it until taken, then record what it should produce.
   task automatic offer_item(input req_type item, input bit typed, input rsp_type want);
      int      gap;
      rsp_type reading;
      gap = steady_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.channel == CH_UNUSED) samples_ignored++;
      else samples_taken++;
      if (predict_reading(item, reading)) begin
         expected_readings.push_back(typed ? want : reading);
         readings_due++;
      end
   endtask

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            mismatches++;
            $display("%0t: reading with none outstanding, expected nothing, got %p",
                     $time, rsp_data);
         end else begin
            want = expected_readings.pop_front();
            readings_checked++;
            check_field("current_ma", want.current_ma, rsp_data.current_ma);
            check_field("input_voltage_mv", want.input_voltage_mv,
                        rsp_data.input_voltage_mv);
            check_field("output_voltage_mv", want.output_voltage_mv,
                        rsp_data.output_voltage_mv);
            check_field("power_mw", want.power_mw, rsp_data.power_mw);
         end
      end
   end

   // Receiver stalls: short random bursts, quiet stretches, one long hold-off on request.
   initial begin : rsp_stall_driver
      int span;
      int served;
      rsp_stall = 1'b0;
      served    = 0;
      forever begin
         @(posedge clock);
         if (hold_off_requests != served) begin
            served = hold_off_requests;
            rsp_stall <= 1'b1;
            span = HOLD_OFF_CYCLES;
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            span = pick_gap();
         end
         repeat (span) @(posedge clock);
      end
   end

   initial begin : watchdog
      #2000000;
      $display("** charge_monitor_average_scale_power_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      req_type item;
      int      pick;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      steady_phase = 1'b0;
      mismatches = 0;
      readings_checked = 0;
      readings_due = 0;
      samples_taken = 0;
      samples_ignored = 0;
      amps_total = 0; vin_total = 0; vout_total = 0;
      amps_taken = 0; vin_taken = 0; vout_taken = 0;
      amps_mean = 0; vin_mean = 0; filtered_ma = 0;
      for (int c = 0; c < 4; c++) level_mode[c] = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            item.channel = directed_rows[r].channel;
            item.sample  = directed_rows[r].sample;
            offer_item(item, directed_rows[r].typed, directed_rows[r].want);
         end
      end

      // Open the random part with a long output hold-off so the core backs up.
      steady_phase = 1'b1;
      hold_off_requests++;
      for (int n = 0; n < RANDOM_SAMPLES; n++) begin
         if (n >= 64 && n % 64 == 0) steady_phase = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 10) item.channel = CH_UNUSED;
         else if (pick < 30) item.channel = CH_CURRENT;
         else if (pick < 50) item.channel = CH_VIN;
         else item.channel = CH_VOUT;
         if ($urandom_range(0, 7) == 0) level_mode[item.channel] = $urandom_range(0, 2);
         case (level_mode[item.channel])
            1: item.sample = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(3968, 4095))
                                                          : 12'hFFF;
            2: item.sample = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 127))
                                                          : 12'h000;
            default: item.sample = 12'($urandom_range(0, 4095));
         endcase
         offer_item(item, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d samples taken, %0d on the unused channel code dropped,",
               samples_taken, samples_ignored);
      $display("     %0d of %0d readings checked field by field, %0d mismatches",
               readings_checked, readings_due, mismatches);
      if (mismatches == 0) begin
         $display("** charge_monitor_average_scale_power_core: PASSED **");
      end else begin
         $display("** charge_monitor_average_scale_power_core: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cmasp_pkg.sv
hw/rtl/cmasp_div.sv
hw/rtl/cmasp_acc.sv
hw/rtl/cmasp_datapath.sv
hw/rtl/cmasp_ctrl.sv
hw/rtl/charge_monitor_average_scale_power_core.sv
verif/tb_charge_monitor_average_scale_power_core.sv
